// ===== hw/rtl/segment_map_translation_table_top_macros.svh =====
// ----------------------------------------------------------------------------
// Segment map translation table: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_MAP_TRANSLATION_TABLE_TOP_MACROS_SVH
`define SEGMENT_MAP_TRANSLATION_TABLE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMTT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/smtt_pkg.sv =====
// ----------------------------------------------------------------------------
// smtt_pkg
// Types, operation codes and defaults for the segment map translation table.
// ----------------------------------------------------------------------------
package smtt_pkg;

  localparam int MAX_SEGMENTS_DEF = 16;

  localparam int ADDR_W   = 32;
  localparam int MODE_W   = 3;
  localparam int CFG_IDX_W = 1;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_MAP       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UNMAP_R   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UNMAP_V   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_XLATE     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REVERSE   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RESERVE   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNRESERVE = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] virt_address;
    logic [ADDR_W-1:0] phys_address;
    logic [ADDR_W-1:0] length_in;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] translated;
    logic [ADDR_W-1:0] removed_length;
    logic [ADDR_W-1:0] window_end;
    logic [ADDR_W-1:0] reserved_now;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] vbase;
    logic [ADDR_W-1:0] rbase;
    logic [ADDR_W-1:0] len;
  } seg_entry_t;

endpackage

// ===== hw/rtl/smtt_ram.sv =====
// ----------------------------------------------------------------------------
// smtt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smtt_ram #(
  parameter int  WIDTH  = 8,
  parameter int  DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/segment_map_translation_table_top.sv =====
// Sequence: an accepted item passes through the prep and exec states; map, reserve, unreserve
// and unused codes then go straight to the finish state. Lookups scan entries in order up to
// the hit or the table end; unmaps scan to the hit and then move each later entry a slot forward.
// One item at a time: the input stalls until the result enters the output register, so a new
// item is accepted only after the previous result has been loaded.
// Reset clears the window registers, segment count and reserved total; the RAM is not cleared.
// ----------------------------------------------------------------------------
// segment_map_translation_table_top
// Ordered segment table with map, unmap, forward and reverse translation
// and reserve control, run by a small sequencer over one segment RAM.
// ----------------------------------------------------------------------------
`include "segment_map_translation_table_top_macros.svh"

module segment_map_translation_table_top #(
  parameter int MAX_SEGMENTS = smtt_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  smtt_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output smtt_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [smtt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smtt_pkg::ADDR_W-1:0]         cfg_wdata
);

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int AW    = smtt_pkg::ADDR_W;
  localparam int ENT_W = $bits(smtt_pkg::seg_entry_t);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]       res_r, res_nxt;
  logic [AW-1:0]       ws_r, wl_r;
  logic                ok_r, ok_nxt;
  logic [AW-1:0]       trans_r, trans_nxt;
  logic [AW-1:0]       removed_r, removed_nxt;
  logic signed [AW+1:0] limit_r, limit_nxt;
  logic [AW:0]         sum_r, sum_nxt;
  smtt_pkg::in_item_t  item_r, item_nxt;
  logic                out_valid_r;
  smtt_pkg::out_item_t out_data_r;
  logic                out_load;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENT_W-1:0]    ram_wdata;
  logic [ENT_W-1:0]    ram_rd_data;
  logic [CNT_W-1:0]    rd_ptr;
  smtt_pkg::seg_entry_t ent;

  logic                is_lookup, is_rev, by_real;
  logic [AW:0]         ent_sum, span;
  logic                ent_fits, unmap_hit, look_hit, hit;
  logic [AW-1:0]       from_a, to_a, addr_a, key_a, ukey_a;
  logic                map_ok, rsv_ok;
  logic [CNT_W-1:0]    idx_p1, idx_p2;

  smtt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (rd_ptr[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  assign ent = smtt_pkg::seg_entry_t'(ram_rd_data);

  assign idx_p1 = idx_r + CNT_W'(1);
  assign idx_p2 = idx_r + CNT_W'(2);

  // Entry match logic for the scan state.
  assign is_lookup = (item_r.mode == smtt_pkg::MODE_XLATE) ||
                     (item_r.mode == smtt_pkg::MODE_REVERSE);
  assign is_rev    = (item_r.mode == smtt_pkg::MODE_REVERSE);
  assign by_real   = (item_r.mode == smtt_pkg::MODE_UNMAP_R);

  assign ent_sum   = {1'b0, ent.vbase} + {1'b0, ent.len};
  assign ent_fits  = (ent.vbase >= ws_r) && ($signed({1'b0, ent_sum}) <= limit_r);
  assign key_a     = by_real ? ent.rbase : ent.vbase;
  assign ukey_a    = by_real ? item_r.phys_address : item_r.virt_address;
  assign unmap_hit = (key_a == ukey_a) && ent_fits;

  assign from_a    = is_rev ? ent.rbase : ent.vbase;
  assign to_a      = is_rev ? ent.vbase : ent.rbase;
  assign addr_a    = is_rev ? item_r.phys_address : item_r.virt_address;
  assign span      = {1'b0, from_a} + {1'b0, ent.len};
  assign look_hit  = (addr_a >= from_a) && ({1'b0, addr_a} < span);
  assign hit       = is_lookup ? look_hit : unmap_hit;

  assign map_ok = (item_r.length_in != '0) && (item_r.virt_address >= ws_r) &&
                  ($signed({1'b0, sum_r}) <= limit_r) &&
                  (cnt_r < CNT_W'(MAX_SEGMENTS));
  assign rsv_ok = ({1'b0, item_r.length_in} + {1'b0, res_r}) <= {1'b0, wl_r};

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    res_nxt     = res_r;
    ok_nxt      = ok_r;
    trans_nxt   = trans_r;
    removed_nxt = removed_r;
    limit_nxt   = limit_r;
    sum_nxt     = sum_r;
    item_nxt    = item_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_r[IDX_W-1:0];
    ram_wdata   = ram_rd_data;
    rd_ptr      = idx_p1;
    out_load    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt    = in_data;
          ok_nxt      = 1'b0;
          trans_nxt   = '0;
          removed_nxt = '0;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        limit_nxt = $signed({2'b00, ws_r}) + $signed({2'b00, wl_r}) - $signed({2'b00, res_r});
        sum_nxt   = {1'b0, item_r.virt_address} + {1'b0, item_r.length_in};
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        rd_ptr    = '0;
        idx_nxt   = '0;
        state_nxt = S_FIN;
        unique case (item_r.mode)
          smtt_pkg::MODE_MAP: begin
            if (map_ok) begin
              ram_we    = 1'b1;
              ram_waddr = cnt_r[IDX_W-1:0];
              ram_wdata = {item_r.virt_address, item_r.phys_address, item_r.length_in};
              cnt_nxt   = cnt_r + CNT_W'(1);
              ok_nxt    = 1'b1;
            end
          end
          smtt_pkg::MODE_UNMAP_R, smtt_pkg::MODE_UNMAP_V,
          smtt_pkg::MODE_XLATE, smtt_pkg::MODE_REVERSE: begin
            if (cnt_r != '0) begin
              state_nxt = S_SCAN;
            end
          end
          smtt_pkg::MODE_RESERVE: begin
            if (rsv_ok) begin
              res_nxt = res_r + item_r.length_in;
              ok_nxt  = 1'b1;
            end
          end
          smtt_pkg::MODE_UNRESERVE: begin
            if (item_r.length_in <= res_r) begin
              res_nxt = res_r - item_r.length_in;
              ok_nxt  = 1'b1;
            end
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
      end
      S_SCAN: begin
        // Read data belongs to entry idx_r; the next entry is being fetched.
        if (hit) begin
          ok_nxt = 1'b1;
          if (is_lookup) begin
            trans_nxt = to_a + (addr_a - from_a);
            state_nxt = S_FIN;
          end else begin
            removed_nxt = ent.len;
            if (idx_p1 < cnt_r) begin
              state_nxt = S_SHIFT;
            end else begin
              cnt_nxt   = cnt_r - CNT_W'(1);
              state_nxt = S_FIN;
            end
          end
        end else if (idx_p1 == cnt_r) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      S_SHIFT: begin
        // Entry idx_r + 1 arrives and moves down into slot idx_r.
        rd_ptr = idx_p2;
        ram_we = 1'b1;
        if (idx_p2 == cnt_r) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      res_r       <= '0;
      ws_r        <= '0;
      wl_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      res_r   <= res_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          smtt_pkg::CFG_WINDOW_START:  ws_r <= cfg_wdata;
          smtt_pkg::CFG_WINDOW_LENGTH: wl_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    ok_r      <= ok_nxt;
    trans_r   <= trans_nxt;
    removed_r <= removed_nxt;
    limit_r   <= limit_nxt;
    sum_r     <= sum_nxt;
    item_r    <= item_nxt;
    if (out_load) begin
      out_data_r.ok             <= ok_r;
      out_data_r.translated     <= trans_r;
      out_data_r.removed_length <= removed_r;
      out_data_r.window_end     <= ws_r + wl_r - res_r;
      out_data_r.reserved_now   <= res_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SMTT_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_SEGMENTS), "segment count overflow")
  `SMTT_ASSERT_SAME(a_scan_idx, state_r == S_SCAN, idx_r < cnt_r, "scan index past table end")
  `SMTT_ASSERT_SAME(a_shift_idx, state_r == S_SHIFT, idx_p1 < cnt_r, "shift source past table end")
  `SMTT_ASSERT_NEXT(a_fin_out, (state_r == S_FIN) && (!out_valid_r || !out_stall),
                    out_valid_r && (state_r == S_IDLE), "finished result not presented")

endmodule

// ===== tb/segment_map_translation_table_checker.sv =====
// ----------------------------------------------------------------------------
// Segment map translation table checker
// Watches the configuration port and both channels, keeps its own copy of the
// segment table and reserved total, predicts one result per accepted
// operation and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module segment_map_translation_table_checker #(
  parameter int TABLE_DEPTH = smtt_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  smtt_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  smtt_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [smtt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smtt_pkg::ADDR_W-1:0]    cfg_wdata,
  output int                             fail_count,
  output int                             pending_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import smtt_pkg::*;

  logic [ADDR_W-1:0] win_start;
  logic [ADDR_W-1:0] win_length;
  logic [ADDR_W-1:0] reserved;
  seg_entry_t        segs [TABLE_DEPTH];
  int                seg_used;
  out_item_t         expected_results [$];
  out_item_t         want;
  out_item_t         fresh;
  int                fails = 0;

  // Upper end of the usable window, exact and possibly negative.
  function automatic longint window_limit();
    return longint'({32'b0, win_start}) + longint'({32'b0, win_length}) -
           longint'({32'b0, reserved});
  endfunction

  function automatic bit fits_window(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size);
    longint reach;
    reach = longint'({32'b0, base}) + longint'({32'b0, size});
    return (base >= win_start) && (reach <= window_limit());
  endfunction

  task automatic predict_result(input in_item_t op, output out_item_t res);
    int                i;
    int                hit;
    bit                by_real;
    bit                reverse;
    logic [ADDR_W-1:0] key;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] from;
    logic [ADDR_W-1:0] to;
    res = '0;
    hit = -1;
    case (op.mode)
      MODE_MAP: begin
        if (op.length_in != 0 && fits_window(op.virt_address, op.length_in) &&
            seg_used < TABLE_DEPTH) begin
          segs[seg_used].vbase = op.virt_address;
          segs[seg_used].rbase = op.phys_address;
          segs[seg_used].len   = op.length_in;
          seg_used++;
          res.ok = 1'b1;
        end
      end
      MODE_UNMAP_R, MODE_UNMAP_V: begin
        by_real = (op.mode == MODE_UNMAP_R);
        key = by_real ? op.phys_address : op.virt_address;
        for (i = 0; i < seg_used && hit < 0; i++) begin
          if ((by_real ? segs[i].rbase : segs[i].vbase) == key &&
              fits_window(segs[i].vbase, segs[i].len))
            hit = i;
        end
        if (hit >= 0) begin
          res.ok = 1'b1;
          res.removed_length = segs[hit].len;
          // Close the gap so the table keeps its mapping order.
          for (i = hit; i + 1 < seg_used; i++)
            segs[i] = segs[i + 1];
          seg_used--;
        end
      end
      MODE_XLATE, MODE_REVERSE: begin
        reverse = (op.mode == MODE_REVERSE);
        addr = reverse ? op.phys_address : op.virt_address;
        for (i = 0; i < seg_used && hit < 0; i++) begin
          from = reverse ? segs[i].rbase : segs[i].vbase;
          to   = reverse ? segs[i].vbase : segs[i].rbase;
          if (addr >= from && {1'b0, addr} < {1'b0, from} + {1'b0, segs[i].len}) begin
            hit = i;
            res.translated = to + (addr - from);
          end
        end
        res.ok = (hit >= 0);
      end
      MODE_RESERVE: begin
        if ({1'b0, op.length_in} + {1'b0, reserved} <= {1'b0, win_length}) begin
          reserved = reserved + op.length_in;
          res.ok = 1'b1;
        end
      end
      MODE_UNRESERVE: begin
        if (op.length_in <= reserved) begin
          reserved = reserved - op.length_in;
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.window_end   = win_start + win_length - reserved;
    res.reserved_now = reserved;
  endtask

  function automatic int field_differs(string name, logic [ADDR_W-1:0] exp_val,
                                       logic [ADDR_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      win_start  = '0;
      win_length = '0;
      reserved   = '0;
      seg_used   = 0;
      expected_results.delete();
    end else begin
      // A result transfer always belongs to an earlier operation, so it is
      // matched before this edge's input transfer is queued.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no operation outstanding");
          fails++;
        end else begin
          want = expected_results.pop_front();
          fails += field_differs("ok", want.ok, out_data.ok);
          fails += field_differs("translated", want.translated, out_data.translated);
          fails += field_differs("removed_length", want.removed_length,
                                 out_data.removed_length);
          fails += field_differs("window_end", want.window_end, out_data.window_end);
          fails += field_differs("reserved_now", want.reserved_now, out_data.reserved_now);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_START:  win_start  = cfg_wdata;
          CFG_WINDOW_LENGTH: win_length = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_result(in_data, fresh);
        expected_results.push_back(fresh);
      end
    end
    pending_results <= expected_results.size();
    fail_count <= fails;
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Segment map translation table testbench
// Drives a directed sequence of map, unmap, lookup and reserve corner cases,
// then random operation mixes over several window settings with varying
// sender gaps and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import smtt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int PHASE_ITEMS     = 215;
  localparam int NUM_PHASES      = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  // Longest operations walk the whole table, scanning it or shifting entries.
  localparam int DRAIN_CYCLES    = 40;
  localparam int RECENT_DEPTH    = 32;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW_START;
  logic [ADDR_W-1:0]    cfg_wdata = '0;

  int                   fail_count;
  int                   pending_results;
  int                   tx_idle_pct = 0;
  int                   rx_idle_pct = 0;
  bit                   hold_trigger = 1'b0;
  bit                   hold_seen = 1'b0;
  int                   hold_left = 0;
  int                   burst_left = 0;
  logic [ADDR_W-1:0]    cur_start = '0;
  logic [ADDR_W-1:0]    cur_length = '0;
  seg_entry_t           recent_maps [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_map_translation_table_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  segment_map_translation_table_checker table_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Result side: random stalls, or one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  function automatic in_item_t make_op(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] va,
                                       logic [ADDR_W-1:0] pa, logic [ADDR_W-1:0] len);
    in_item_t op;
    op.mode = mode;
    op.virt_address = va;
    op.phys_address = pa;
    op.length_in = len;
    return op;
  endfunction

  // Both window registers are written back to back with the enable held.
  task automatic write_window(input logic [ADDR_W-1:0] start_addr,
                              input logic [ADDR_W-1:0] span);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW_START;
    cfg_wdata <= start_addr;
    @(negedge clk);
    cfg_index <= CFG_WINDOW_LENGTH;
    cfg_wdata <= span;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_start = start_addr;
    cur_length = span;
  endtask

  task automatic send_op(input in_item_t op);
    seg_entry_t seg;
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (op.mode == MODE_MAP) begin
      seg.vbase = op.virt_address;
      seg.rbase = op.phys_address;
      seg.len = op.length_in;
      recent_maps.push_back(seg);
      if (recent_maps.size() > RECENT_DEPTH) void'(recent_maps.pop_front());
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly operations aimed at the window and at recently mapped segments,
  // with bursts of maps that fill the table and a share of raw noise.
  function automatic in_item_t random_op();
    in_item_t          op;
    seg_entry_t        pick;
    int                roll;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] reach;
    op = make_op(MODE_UNUSED, $urandom, $urandom, $urandom);
    span = (cur_length == 0) ? '0 : cur_length - 1;
    if (recent_maps.size() != 0) begin
      pick = recent_maps[$urandom_range(0, recent_maps.size() - 1)];
    end else begin
      pick.vbase = $urandom;
      pick.rbase = $urandom;
      pick.len = 1;
    end
    reach = (pick.len == 0) ? '0 : ((pick.len > 256) ? 255 : pick.len - 1);
    if (burst_left > 0) begin
      burst_left--;
      roll = 0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 2) burst_left = 16;
    end
    if (roll < 32) begin
      op.mode = MODE_MAP;
      case ($urandom_range(0, 9))
        0:       offset = '0;
        1:       offset = span;
        2, 3, 4: offset = $urandom_range(0, (span < 255) ? span : 255);
        default: offset = $urandom_range(0, span);
      endcase
      op.virt_address = cur_start + offset;
      case ($urandom_range(0, 19))
        0:       op.length_in = '0;
        1:       op.length_in = $urandom;
        2, 3, 4: op.length_in = $urandom_range(1, 32'h10000);
        default: op.length_in = $urandom_range(1, 64);
      endcase
    end else if (roll < 42) begin
      op.mode = MODE_UNMAP_R;
      if ($urandom_range(0, 9) != 0) op.phys_address = pick.rbase;
    end else if (roll < 52) begin
      op.mode = MODE_UNMAP_V;
      if ($urandom_range(0, 9) != 0) op.virt_address = pick.vbase;
    end else if (roll < 70) begin
      op.mode = MODE_XLATE;
      if ($urandom_range(0, 6) != 0)
        op.virt_address = pick.vbase + $urandom_range(0, reach + (pick.len > 256));
    end else if (roll < 85) begin
      op.mode = MODE_REVERSE;
      if ($urandom_range(0, 6) != 0)
        op.phys_address = pick.rbase + $urandom_range(0, reach + (pick.len > 256));
    end else if (roll < 91) begin
      op.mode = MODE_RESERVE;
      if ($urandom_range(0, 4) != 0) op.length_in = $urandom_range(0, cur_length >> 3);
    end else if (roll < 97) begin
      op.mode = MODE_UNRESERVE;
      if ($urandom_range(0, 4) != 0) op.length_in = $urandom_range(0, cur_length >> 3);
    end else begin
      op.mode = MODE_W'($urandom_range(0, 7));
    end
    return op;
  endfunction

  initial begin
    int phase;
    int n;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corner cases in a window of 0x1000..0x11000.
    write_window(32'h0000_1000, 32'h0001_0000);
    send_op(make_op(MODE_MAP, 32'h0000_1000, 32'h0000_2000, 32'h0));
    send_op(make_op(MODE_MAP, 32'h0000_0FFF, 32'h0000_2000, 32'h10));
    send_op(make_op(MODE_MAP, 32'h0001_0FF0, 32'h0000_2000, 32'h11));
    send_op(make_op(MODE_MAP, 32'h0000_1000, 32'hFFFF_FFF0, 32'h100));
    // Forward and reverse lookups on a segment whose physical range wraps, and a miss past its end.
    send_op(make_op(MODE_XLATE, 32'h0000_1020, 32'h0, 32'h0));
    send_op(make_op(MODE_REVERSE, 32'h0, 32'hFFFF_FFFF, 32'h0));
    send_op(make_op(MODE_XLATE, 32'h0000_1100, 32'h0, 32'h0));
    // Overlapping segment: the older entry must win the lookup.
    send_op(make_op(MODE_MAP, 32'h0000_1080, 32'h0000_5000, 32'h80));
    send_op(make_op(MODE_XLATE, 32'h0000_1080, 32'h0, 32'h0));
    send_op(make_op(MODE_REVERSE, 32'h0, 32'h0000_507F, 32'h0));
    send_op(make_op(MODE_RESERVE, 32'h0, 32'h0, 32'h0001_0001));
    // Shrink the window so neither segment fits; unmap must skip them.
    send_op(make_op(MODE_RESERVE, 32'h0, 32'h0, 32'h0000_FF01));
    send_op(make_op(MODE_UNMAP_V, 32'h0000_1000, 32'h0, 32'h0));
    send_op(make_op(MODE_MAP, 32'h0000_1000, 32'h0000_9000, 32'hFF));
    send_op(make_op(MODE_UNRESERVE, 32'h0, 32'h0, 32'h0000_FF02));
    send_op(make_op(MODE_UNRESERVE, 32'h0, 32'h0, 32'h0000_FF01));
    send_op(make_op(MODE_UNMAP_R, 32'h0, 32'h0000_5000, 32'h0));
    send_op(make_op(MODE_UNMAP_V, 32'h0000_1000, 32'h0, 32'h0));
    send_op(make_op(MODE_XLATE, 32'h0000_1000, 32'h0, 32'h0));
    send_op(make_op(MODE_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_op(make_op(MODE_UNMAP_R, 32'h0, 32'hFFFF_FFFF, 32'h0));
    send_op(make_op(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_op(make_op(MODE_RESERVE, 32'h0, 32'h0, 32'h0001_0000));

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: write_window(32'h0000_1000, 32'h0001_0000);
        1: write_window(32'h0000_0000, 32'hFFFF_FFFF);
        // Zero length: with any reservation left the limit goes negative.
        2: write_window(32'h0000_0000, 32'h0000_0000);
        3: write_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        4: write_window($urandom, $urandom_range(32'h100, 32'h10_0000));
        5: write_window(32'hFFFF_0000, 32'h0010_0000);
        6: write_window($urandom, $urandom);
        default: write_window(32'h8000_0000, 32'h0000_4000);
      endcase
      case (phase % 4)
        0: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
        1: begin
          tx_idle_pct = 53;
          rx_idle_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 53;
        end
        default: begin
          tx_idle_pct = 32;
          rx_idle_pct <= 32;
        end
      endcase
      // The sender keeps offering during the hold-off so the block backs up.
      if (phase == 0) hold_trigger <= ~hold_trigger;
      for (n = 0; n < PHASE_ITEMS; n++)
        send_op(random_op());
    end

    wait_idle();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/smtt_pkg.sv
hw/rtl/smtt_ram.sv
hw/rtl/segment_map_translation_table_top.sv
tb/segment_map_translation_table_checker.sv
tb/testbench.sv
